FILE: hdl/fcs_pkg.sv
`timescale 1ns / 1ps

package fcs_pkg;

  // Frame layout
  localparam logic [7:0]  HEAD_LOW       = 8'h5A;
  localparam logic [7:0]  HEAD_HIGH      = 8'hA5;
  localparam logic [15:0] MIN_FRAME      = 16'd9;
  localparam logic [15:0] SUM_START      = 16'd5;
  localparam logic [15:0] OFS_HEAD_HIGH  = 16'd1;
  localparam logic [15:0] OFS_SOURCE     = 16'd4;
  localparam logic [15:0] OFS_MESSAGE    = 16'd5;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

  // Configuration
  localparam int unsigned CFG_AW         = 3;
  localparam logic        REG_MAX_LEN    = 1'b0;
  localparam logic [15:0] MAX_LEN_RESET  = 16'hFFFF;

  // Output beat layout
  localparam int unsigned OUT_DW         = 48;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QUEUE_AW       = 2;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_LONG  = 3'd2,
    ST_HEAD  = 3'd3,
    ST_SUM   = 3'd4
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [15:0] payload_len;
    status_t     status;
    logic [7:0]  msg_type;
    logic [7:0]  source_id;
    logic [7:0]  out_byte;
  } result_fields_t;

  typedef struct packed {
    kind_t          kind;
    logic           last;
    result_fields_t fields;
  } result_t;

endpackage

FILE: hdl/frame_checker_sum_checksum_core.sv
`timescale 1ns / 1ps

// Byte-stream frame checker with an 8-bit additive checksum.
// in_*  : one received byte per beat, tlast marks the final byte of a frame.
// out_* : result beats. tuser says payload byte (0) or end-of-frame status (1);
//         tlast marks the last result beat caused by one input byte.
// cfg_* : APB-style register port, register 0 at address 0 = max_payload_len.
// Payload bytes are released once three more bytes have arrived behind them,
// and only when the head matched. The final byte of each frame adds a status
// beat (ok, too short, too long, bad head, bad checksum); a frame whose status
// is not ok must be dropped downstream, since its payload already went out.
// Throughput: one input byte per cycle while results are taken at that pace;
// a byte that yields two results (last payload plus status) needs two output
// beats. A four-entry result queue sits between the frame logic and the
// output; in_tready drops while fewer than two entries are free, so a stalled
// receiver stops input before the queue overflows and nothing is lost.
// Reset clears all frame state and the queue, and sets max_payload_len to 65535.
module frame_checker_sum_checksum_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] in_byte
  input  logic                       in_tlast,   // in_last
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [7:0] out_byte, [15:8] source_id, [23:16] msg_type, [26:24] status,
  // [42:27] payload_len, [47:43] zero
  output logic [fcs_pkg::OUT_DW-1:0] out_tdata,
  output logic                       out_tuser,  // out_kind
  output logic                       out_tlast,  // out_last
  // configuration
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [fcs_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  import fcs_pkg::*;

  // Registers
  logic [15:0] max_len_r;
  logic [15:0] byte_count_r,  byte_count_nxt;
  logic [7:0]  head_low_r,    head_low_nxt;
  logic        head_good_r,   head_good_nxt;
  logic [7:0]  source_r,      source_nxt;
  logic [7:0]  message_r,     message_nxt;
  logic [7:0]  sum_r,         sum_nxt;
  logic [7:0]  delay0_r,      delay0_nxt;
  logic [7:0]  delay1_r,      delay1_nxt;
  logic [7:0]  delay2_r,      delay2_nxt;

  result_t              queue_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]    count_r,  count_nxt;

  logic        in_fire, out_fire, cfg_write;
  logic        emit_payload;
  logic [16:0] k_plus1;
  logic [15:0] plen;
  status_t     st;
  result_t     pay_res, stat_res, res0, res1;
  logic [1:0]  push_n;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_write && (cfg_paddr[2] == REG_MAX_LEN)) begin
      max_len_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_LEN) ? {16'd0, max_len_r} : 32'd0;

  // Handshakes
  assign in_tready  = (count_r <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = (count_r != '0);
  assign out_fire   = out_tvalid && out_tready;

  // Frame state update for the incoming byte
  always_comb begin
    head_low_nxt  = head_low_r;
    head_good_nxt = head_good_r;
    source_nxt    = source_r;
    message_nxt   = message_r;
    sum_nxt       = sum_r;

    if (byte_count_r == '0) begin
      head_low_nxt = in_tdata;
    end else if (byte_count_r == OFS_HEAD_HIGH) begin
      head_good_nxt = (head_low_r == HEAD_LOW) && (in_tdata == HEAD_HIGH);
    end else if (byte_count_r == OFS_SOURCE) begin
      source_nxt = in_tdata;
    end else if (byte_count_r == OFS_MESSAGE) begin
      message_nxt = in_tdata;
    end

    // accumulate the byte leaving the delay line
    if (byte_count_r >= SUM_START) begin
      sum_nxt = sum_r + delay2_r;
    end

    emit_payload = (byte_count_r >= MIN_FRAME) && head_good_nxt;

    // payload length and status on the final byte
    k_plus1 = {1'b0, byte_count_r} + 17'd1;
    if (byte_count_r == COUNT_MAX) begin
      plen = COUNT_MAX;
    end else if (k_plus1 >= {1'b0, MIN_FRAME}) begin
      plen = 16'(k_plus1 - {1'b0, MIN_FRAME});
    end else begin
      plen = '0;
    end

    if (k_plus1 < {1'b0, MIN_FRAME}) begin
      st = ST_SHORT;
    end else if (plen > max_len_r) begin
      st = ST_LONG;
    end else if (!head_good_nxt) begin
      st = ST_HEAD;
    end else if (sum_nxt != delay1_r) begin
      st = ST_SUM;
    end else begin
      st = ST_OK;
    end

    // next frame state: clear on the final byte, else shift and count
    if (in_tlast) begin
      byte_count_nxt = '0;
      head_low_nxt   = '0;
      head_good_nxt  = 1'b0;
      source_nxt     = '0;
      message_nxt    = '0;
      sum_nxt        = '0;
      delay0_nxt     = '0;
      delay1_nxt     = '0;
      delay2_nxt     = '0;
    end else begin
      byte_count_nxt = (byte_count_r == COUNT_MAX) ? COUNT_MAX : byte_count_r + 16'd1;
      delay0_nxt     = in_tdata;
      delay1_nxt     = delay0_r;
      delay2_nxt     = delay1_r;
    end
  end

  // Build the result beats for this byte
  always_comb begin
    pay_res                    = '0;
    pay_res.kind               = KIND_PAYLOAD;
    pay_res.last               = !in_tlast;
    pay_res.fields.out_byte    = delay2_r;
    pay_res.fields.source_id   = (byte_count_r == OFS_SOURCE)  ? in_tdata : source_r;
    pay_res.fields.msg_type    = (byte_count_r == OFS_MESSAGE) ? in_tdata : message_r;
    pay_res.fields.status      = ST_OK;

    stat_res                   = pay_res;
    stat_res.kind              = KIND_STATUS;
    stat_res.last              = 1'b1;
    stat_res.fields.out_byte   = '0;
    stat_res.fields.status     = st;
    stat_res.fields.payload_len = plen;

    res0 = emit_payload ? pay_res : stat_res;
    res1 = stat_res;

    if (!in_fire) begin
      push_n = 2'd0;
    end else begin
      push_n = 2'(emit_payload) + 2'(in_tlast);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      head_low_r   <= '0;
      head_good_r  <= 1'b0;
      source_r     <= '0;
      message_r    <= '0;
      sum_r        <= '0;
      delay0_r     <= '0;
      delay1_r     <= '0;
      delay2_r     <= '0;
    end else if (in_fire) begin
      byte_count_r <= byte_count_nxt;
      head_low_r   <= head_low_nxt;
      head_good_r  <= head_good_nxt;
      source_r     <= source_nxt;
      message_r    <= message_nxt;
      sum_r        <= sum_nxt;
      delay0_r     <= delay0_nxt;
      delay1_r     <= delay1_nxt;
      delay2_r     <= delay2_nxt;
    end
  end

  // Result queue: push up to two beats, pop one
  assign count_nxt = count_r + (QUEUE_AW+1)'(push_n) - (QUEUE_AW+1)'(out_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QUEUE_AW'(push_n);
      rd_ptr_r <= rd_ptr_r + QUEUE_AW'(out_fire);
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      queue_r[wr_ptr_r + QUEUE_AW'(1)] <= res1;
    end
  end

  // Output
  assign out_tdata = OUT_DW'(queue_r[rd_ptr_r].fields);
  assign out_tuser = queue_r[rd_ptr_r].kind;
  assign out_tlast = queue_r[rd_ptr_r].last;

  // Assertions
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (byte_count_r == '0 && sum_r == '0 && !head_good_r))
    else $error("frame state not cleared after final byte");

  a_payload_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && emit_payload) |-> (byte_count_r >= MIN_FRAME))
    else $error("payload released inside the header");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_PAYLOAD) |->
      (out_tdata[26:24] == ST_OK && out_tdata[42:27] == '0))
    else $error("payload beat carries status fields");

endmodule
